>>> rtl/core/stia_pkg.sv
// ----------------------------------------------------------------------------
// stia_pkg - shared definitions for the slot table with identifier allocation
// Command codes, controller states, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package stia_pkg;

    // Default sizes of the table.
    localparam int DEF_MAX_SLOTS    = 64;
    localparam int DEF_IDENT_BITS   = 16;
    localparam int DEF_PAYLOAD_BITS = 64;

    // Widths of the fields on the ports.
    localparam int CFG_W       = 7;
    localparam int CMD_W       = 3;
    localparam int KEY_W       = 16;
    localparam int PAY_W       = 64;
    localparam int IDX_OUT_W   = 6;
    localparam int ID_OUT_W    = 16;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 88;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_MODIFY = 3'd3,
        CMD_FIND   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

endpackage

>>> rtl/core/stia_store.sv
// ----------------------------------------------------------------------------
// stia_store - identifier and payload memories of the slot table
// One write port with separate enables per field, one read port whose data
// is registered.
// ----------------------------------------------------------------------------
module stia_store #(
    parameter int DEPTH  = 64,
    parameter int ID_W   = 16,
    parameter int DATA_W = 64
) (
    input  logic                     aclk,
    input  logic                     ident_we,
    input  logic                     data_we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [ID_W-1:0]          wr_ident,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ID_W-1:0]          rd_ident,
    output logic [DATA_W-1:0]        rd_data
);

    logic [ID_W-1:0]   ident_mem [DEPTH];
    logic [DATA_W-1:0] data_mem  [DEPTH];
    logic [ID_W-1:0]   rd_ident_reg;
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ident_we) begin
            ident_mem[wr_addr] <= wr_ident;
        end
        if (data_we) begin
            data_mem[wr_addr] <= wr_data;
        end
        rd_ident_reg <= ident_mem[rd_addr];
        rd_data_reg  <= data_mem[rd_addr];
    end

    assign rd_ident = rd_ident_reg;
    assign rd_data  = rd_data_reg;

endmodule

>>> rtl/core/slot_table_with_id_alloc_top.sv
// ----------------------------------------------------------------------------
// slot_table_with_id_alloc_top - slot table with first-free allocation
// Table of slots holding a valid mark, an identifier and a payload word,
// driven by clear, add, remove, modify and find commands.
// ----------------------------------------------------------------------------
// The block keeps a table of MAX_SLOTS slots, of which the lowest
// active_slots take part in searching, allocation and clearing. Each command
// arrives as one input transfer and yields exactly one result transfer. Add
// places the payload in the lowest free slot and gives it the next identifier
// from a counter that starts at 1 and wraps; remove, modify and find act on
// the lowest valid slot whose identifier equals key_id. Identifiers and
// payloads live in a memory with registered read data, and a command walks
// the active slots one per cycle through that memory's read port, stopping
// at the first slot that matches; clear all, an unknown command and a
// table with no active slots skip the search and go straight to the result.
// The block works on one command at a time; a finished result sits
// in the output register, and the next command is taken while it waits.
// The valid marks are flip-flops cleared by reset, so the table is usable
// straight after reset with no clearing pass. The active_slots register may
// be written only while no command is outstanding; a value above MAX_SLOTS
// counts as MAX_SLOTS and a value of zero makes every command fail.
// ----------------------------------------------------------------------------
module slot_table_with_id_alloc_top #(
    parameter int MAX_SLOTS    = stia_pkg::DEF_MAX_SLOTS,
    parameter int IDENT_BITS   = stia_pkg::DEF_IDENT_BITS,
    parameter int PAYLOAD_BITS = stia_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration: active_slots.
    input  logic                               cfg_wr_en,
    input  logic [stia_pkg::CFG_W-1:0]         cfg_wr_data,
    // Command channel.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [stia_pkg::IN_TDATA_W-1:0]    s_tdata,  // key_id[15:0], payload[79:16]
    input  logic [stia_pkg::CMD_W-1:0]         s_tuser,  // cmd[2:0]
    // Result channel.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stia_pkg::OUT_TDATA_W-1:0]   m_tdata,  // slot_index[5:0], entry_id[21:6],
                                                         // entry_payload[85:22], zero[87:86]
    output logic                               m_tuser   // ok[0]
);

    import stia_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    // Count width: wide enough for MAX_SLOTS itself and for the register.
    localparam int CNT_RAW = $clog2(MAX_SLOTS + 1);
    localparam int CNT_W   = (CNT_RAW > CFG_W) ? CNT_RAW : CFG_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

    // ------------------------------------------------------------------
    // Configuration register and the number of live slots.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] active_reg;
    logic [CNT_W-1:0] active_ext;
    logic [CNT_W-1:0] live_cnt;
    logic [CNT_W-1:0] last_cnt;
    logic             live_any;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
        end else if (cfg_wr_en) begin
            active_reg <= cfg_wr_data;
        end
    end

    assign active_ext = CNT_W'(active_reg);
    assign live_cnt   = (active_ext > MAX_CNT) ? MAX_CNT : active_ext;
    assign live_any   = (live_cnt != '0);
    assign last_cnt   = live_cnt - CNT_W'(1);

    // ------------------------------------------------------------------
    // Registers of the controller.
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [IDENT_BITS-1:0]  key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [IDX_W-1:0]       addr_reg, addr_next;
    logic [IDX_W-1:0]       chk_reg, chk_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [PAYLOAD_BITS-1:0] hit_data_reg, hit_data_next;
    logic [IDENT_BITS-1:0]  next_ident_reg, next_ident_next;
    logic [MAX_SLOTS-1:0]   valid_reg, valid_next;

    logic                   out_vld_reg, out_vld_next;
    logic                   out_ok_reg, out_ok_next;
    logic [IDX_OUT_W-1:0]   out_idx_reg, out_idx_next;
    logic [ID_OUT_W-1:0]    out_id_reg, out_id_next;
    logic [PAY_W-1:0]       out_pay_reg, out_pay_next;

    // Memory ports.
    logic                    ident_we;
    logic                    data_we;
    logic [IDENT_BITS-1:0]   wr_ident;
    logic [PAYLOAD_BITS-1:0] wr_data;
    logic [IDENT_BITS-1:0]   rd_ident;
    logic [PAYLOAD_BITS-1:0] rd_data;

    // Width conversions between port fields and stored fields.
    logic [IDENT_BITS+KEY_W-1:0]   key_wide;
    logic [IDENT_BITS+ID_OUT_W-1:0] id_wide;
    logic [PAYLOAD_BITS+PAY_W-1:0] pay_wide;
    logic [IDX_W+IDX_OUT_W-1:0]    idx_wide;
    logic [IDENT_BITS-1:0]         id_res;
    logic [PAYLOAD_BITS-1:0]       pay_res;
    logic [IDENT_BITS-1:0]         ident_inc;

    logic s_fire;
    logic out_free;
    logic cmd_valid;
    logic chk_last;
    logic chk_hit;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;
    assign key_wide = {{IDENT_BITS{1'b0}}, s_tdata[KEY_W-1:0]};
    assign ident_inc = next_ident_reg + IDENT_BITS'(1);
    assign chk_last = (CNT_W'(chk_reg) == last_cnt);

    always_comb begin
        case (cmd_t'(s_tuser))
            CMD_CLEAR, CMD_ADD, CMD_REMOVE, CMD_MODIFY, CMD_FIND: cmd_valid = 1'b1;
            default:                                              cmd_valid = 1'b0;
        endcase
    end

    // The slot under test: a free slot for add, a valid slot holding the key
    // for the other commands. Read data belongs to chk_reg.
    always_comb begin
        case (cmd_reg)
            CMD_ADD: chk_hit = !valid_reg[chk_reg];
            default: chk_hit = valid_reg[chk_reg] && (rd_ident == key_reg);
        endcase
    end

    // Result fields before narrowing to the port widths.
    always_comb begin
        case (cmd_reg)
            CMD_ADD: begin
                id_res  = ident_inc;
                pay_res = pay_reg;
            end
            CMD_MODIFY: begin
                id_res  = key_reg;
                pay_res = pay_reg;
            end
            default: begin
                id_res  = key_reg;
                pay_res = hit_data_reg;
            end
        endcase
    end

    assign id_wide  = {{ID_OUT_W{1'b0}}, id_res};
    assign pay_wide = {{PAY_W{1'b0}}, pay_res};
    assign idx_wide = {{IDX_OUT_W{1'b0}}, hit_idx_reg};

    // ------------------------------------------------------------------
    // State register and datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            chk_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            next_ident_reg <= '0;
            valid_reg      <= '0;
            out_vld_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            chk_vld_reg    <= chk_vld_next;
            hit_reg        <= hit_next;
            next_ident_reg <= next_ident_next;
            valid_reg      <= valid_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        addr_reg     <= addr_next;
        chk_reg      <= chk_next;
        hit_idx_reg  <= hit_idx_next;
        hit_data_reg <= hit_data_next;
        out_ok_reg   <= out_ok_next;
        out_idx_reg  <= out_idx_next;
        out_id_reg   <= out_id_next;
        out_pay_reg  <= out_pay_next;
    end

    // ------------------------------------------------------------------
    // Next state and outputs.
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        addr_next       = addr_reg;
        chk_next        = chk_reg;
        chk_vld_next    = chk_vld_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_data_next   = hit_data_reg;
        next_ident_next = next_ident_reg;
        valid_next      = valid_reg;
        out_vld_next    = out_vld_reg;
        out_ok_next     = out_ok_reg;
        out_idx_next    = out_idx_reg;
        out_id_next     = out_id_reg;
        out_pay_next    = out_pay_reg;
        ident_we        = 1'b0;
        data_we         = 1'b0;
        wr_ident        = ident_inc;
        wr_data         = pay_reg;
        s_tready        = 1'b0;

        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_fire) begin
                    cmd_next     = cmd_t'(s_tuser);
                    key_next     = key_wide[IDENT_BITS-1:0];
                    pay_next     = s_tdata[KEY_W +: PAYLOAD_BITS];
                    hit_next     = 1'b0;
                    hit_idx_next = '0;
                    addr_next    = '0;
                    chk_vld_next = 1'b0;
                    // Clear, unknown commands and an empty table need no search.
                    if (live_any && cmd_valid && (cmd_t'(s_tuser) != CMD_CLEAR)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN: begin
                // Issue the next read while the previous slot is tested.
                chk_next     = addr_reg;
                chk_vld_next = 1'b1;
                if (CNT_W'(addr_reg) != last_cnt) begin
                    addr_next = addr_reg + IDX_W'(1);
                end
                if (chk_vld_reg) begin
                    if (chk_hit) begin
                        hit_next      = 1'b1;
                        hit_idx_next  = chk_reg;
                        hit_data_next = rd_data;
                        state_next    = ST_DONE;
                        chk_vld_next  = 1'b0;
                    end else if (chk_last) begin
                        state_next   = ST_DONE;
                        chk_vld_next = 1'b0;
                    end
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    out_vld_next = 1'b1;
                    if (hit_reg) begin
                        out_ok_next  = 1'b1;
                        out_idx_next = idx_wide[IDX_OUT_W-1:0];
                        out_id_next  = id_wide[ID_OUT_W-1:0];
                        out_pay_next = pay_wide[PAY_W-1:0];
                        case (cmd_reg)
                            CMD_ADD: begin
                                valid_next[hit_idx_reg] = 1'b1;
                                next_ident_next         = ident_inc;
                                ident_we                = 1'b1;
                                data_we                 = 1'b1;
                            end
                            CMD_REMOVE: begin
                                valid_next[hit_idx_reg] = 1'b0;
                            end
                            CMD_MODIFY: begin
                                data_we = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        out_ok_next  = live_any && (cmd_reg == CMD_CLEAR);
                        out_idx_next = '0;
                        out_id_next  = '0;
                        out_pay_next = '0;
                        if (live_any && (cmd_reg == CMD_CLEAR)) begin
                            for (int i = 0; i < MAX_SLOTS; i++) begin
                                if (CNT_W'(i) < live_cnt) begin
                                    valid_next[i] = 1'b0;
                                end
                            end
                        end
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Identifier and payload memories.
    // ------------------------------------------------------------------
    stia_store #(
        .DEPTH  (MAX_SLOTS),
        .ID_W   (IDENT_BITS),
        .DATA_W (PAYLOAD_BITS)
    ) u_store (
        .aclk     (aclk),
        .ident_we (ident_we),
        .data_we  (data_we),
        .wr_addr  (hit_idx_reg),
        .wr_ident (wr_ident),
        .wr_data  (wr_data),
        .rd_addr  (addr_reg),
        .rd_ident (rd_ident),
        .rd_data  (rd_data)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {2'b00, out_pay_reg, out_id_reg, out_idx_reg};

endmodule

>>> tb/slot_table_with_id_alloc_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_table_with_id_alloc_top_tb - self-checking bench for the slot table
// Runs a table of directed commands, then random command streams under
// several active sizes. Results are checked against a copy of the table.
// ----------------------------------------------------------------------------
// Every command transfer yields exactly one result transfer. The bench keeps
// its own copy of the table (valid marks, identifiers, payloads, identifier
// counter and active size), applies each accepted command to that copy, and
// queues the result it gives. Results leaving the block are checked field by
// field against the oldest queued one. Directed rows whose outcome is plain
// (empty table, extremes, failures) carry a typed-in result instead.
// ----------------------------------------------------------------------------
module slot_table_with_id_alloc_top_tb;
    import stia_pkg::*;

    localparam int SLOTS = DEF_MAX_SLOTS;

    // Command codes the block does not know; they must fail and change nothing.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

    localparam logic [PAY_W-1:0] ALL_ONES = {PAY_W{1'b1}};

    typedef struct packed {
        logic                 ok;
        logic [IDX_OUT_W-1:0] slot;
        logic [ID_OUT_W-1:0]  ident;
        logic [PAY_W-1:0]     data;
    } table_result_t;

    localparam table_result_t NO_RESULT = '0;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_CONFIG
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [CFG_W-1:0] active;
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        table_result_t    want;
    } directed_row_t;

    typedef struct {
        logic [CFG_W-1:0] active;
        int               send_idle;
        int               recv_stall;
        int               add_pct;
        int               items;
    } phase_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // key_id[15:0], payload[79:16]
    logic [CMD_W-1:0]       s_tuser;   // cmd[2:0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // slot_index[5:0], entry_id[21:6],
                                       // entry_payload[85:22], zero[87:86]
    logic                   m_tuser;   // ok[0]

    // Bench copy of the table.
    logic                   copy_valid [SLOTS];
    logic [KEY_W-1:0]       copy_ident [SLOTS];
    logic [PAY_W-1:0]       copy_data  [SLOTS];
    logic [KEY_W-1:0]       copy_next_id;
    logic [CFG_W-1:0]       copy_active;

    table_result_t          awaited_results [$];
    int                     mismatch_count = 0;
    int                     send_idle_pct  = 0;
    int                     recv_stall_pct = 0;

    slot_table_with_id_alloc_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Applies one command to the bench copy and returns the result it gives.
    // Only the lowest active slots are searched; a size above the table
    // counts as the whole table, and a size of zero makes everything fail.
    function automatic table_result_t table_copy_apply(input logic [CMD_W-1:0] op,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [PAY_W-1:0] pay);
        table_result_t res;
        int            n;
        int            hit;
        res = NO_RESULT;
        hit = -1;
        n = (copy_active > SLOTS) ? SLOTS : int'(copy_active);
        if (n > 0) begin
            case (op)
                CMD_CLEAR: begin
                    for (int i = 0; i < n; i++) copy_valid[i] = 1'b0;
                    res.ok = 1'b1;
                end
                CMD_ADD: begin
                    for (int i = n - 1; i >= 0; i--) if (!copy_valid[i]) hit = i;
                    if (hit >= 0) begin
                        // The counter only moves on a successful add.
                        copy_next_id    = copy_next_id + 1'b1;
                        copy_valid[hit] = 1'b1;
                        copy_ident[hit] = copy_next_id;
                        copy_data[hit]  = pay;
                        res.ok          = 1'b1;
                    end
                end
                CMD_REMOVE, CMD_MODIFY, CMD_FIND: begin
                    for (int i = n - 1; i >= 0; i--) begin
                        if (copy_valid[i] && copy_ident[i] == key) hit = i;
                    end
                    if (hit >= 0) begin
                        if (op == CMD_REMOVE) copy_valid[hit] = 1'b0;
                        if (op == CMD_MODIFY) copy_data[hit] = pay;
                        res.ok = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (res.ok && hit >= 0) begin
            res.slot  = hit[IDX_OUT_W-1:0];
            res.ident = copy_ident[hit];
            res.data  = copy_data[hit];
        end
        return res;
    endfunction

    // Mostly identifiers that are live somewhere in the table, so that
    // remove, modify and find get past the search; the rest are arbitrary.
    function automatic logic [KEY_W-1:0] pick_key();
        int live [$];
        for (int i = 0; i < SLOTS; i++) if (copy_valid[i]) live.push_back(i);
        if (live.size() > 0 && $urandom_range(99) < 75) begin
            return copy_ident[live[$urandom_range(live.size() - 1)]];
        end
        if ($urandom_range(1) == 0) return copy_next_id + KEY_W'($urandom_range(1));
        return KEY_W'($urandom());
    endfunction

    // Offers one command, holding it until the block takes it, and records
    // the result it should give. A gap before the transfer drops tvalid.
    task automatic send_command(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [PAY_W-1:0] pay, input bit typed,
                                input table_result_t typed_res);
        table_result_t predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pay, key};
        do @(posedge aclk); while (!s_tready);
        predicted = table_copy_apply(op, key, pay);
        awaited_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    // The size register may only change with no command outstanding.
    task automatic write_active(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        copy_active = value;
    endtask

    task automatic report_field(input string field, input logic [PAY_W-1:0] want,
                                input logic [PAY_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
        end
    endtask

    // Receiver side: random back-pressure and the result check.
    always @(posedge aclk) begin
        table_result_t got;
        table_result_t want;
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.ok    = m_tuser;
            got.slot  = m_tdata[IDX_OUT_W-1:0];
            got.ident = m_tdata[IDX_OUT_W+ID_OUT_W-1:IDX_OUT_W];
            got.data  = m_tdata[IDX_OUT_W+ID_OUT_W+PAY_W-1:IDX_OUT_W+ID_OUT_W];
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result transfer expected none, got %h", $time, got);
            end else begin
                want = awaited_results.pop_front();
                report_field("ok", PAY_W'(want.ok), PAY_W'(got.ok));
                report_field("slot_index", PAY_W'(want.slot), PAY_W'(got.slot));
                report_field("entry_id", PAY_W'(want.ident), PAY_W'(got.ident));
                report_field("entry_payload", want.data, got.data);
            end
        end
    end

    // Directed commands. Typed rows give the result outright; the others
    // rely on the bench copy. The run starts at the reset size of 64.
    directed_row_t directed_rows [30] = '{
        '{ROW_TYPED,   7'd0,   CMD_FIND,       16'd1,      64'd0,      NO_RESULT},
        '{ROW_TYPED,   7'd0,   CMD_REMOVE,     16'hFFFF,   64'd0,      NO_RESULT},
        '{ROW_TYPED,   7'd0,   CMD_ADD,        16'hFFFF,   ALL_ONES,
          {1'b1, 6'd0, 16'd1, ALL_ONES}},
        '{ROW_TYPED,   7'd0,   CMD_ADD,        16'd0,      64'd0,
          {1'b1, 6'd1, 16'd2, 64'd0}},
        '{ROW_TYPED,   7'd0,   CMD_FIND,       16'd1,      64'd0,
          {1'b1, 6'd0, 16'd1, ALL_ONES}},
        '{ROW_TYPED,   7'd0,   CMD_MODIFY,     16'd2,      64'hA5A5_A5A5_A5A5_A5A5,
          {1'b1, 6'd1, 16'd2, 64'hA5A5_A5A5_A5A5_A5A5}},
        '{ROW_TYPED,   7'd0,   CMD_REMOVE,     16'd1,      64'd0,
          {1'b1, 6'd0, 16'd1, ALL_ONES}},
        '{ROW_PREDICT, 7'd0,   CMD_ADD,        16'd0,      64'h0123_4567_89AB_CDEF, NO_RESULT},
        '{ROW_TYPED,   7'd0,   CMD_UNKNOWN_LO, 16'd3,      ALL_ONES,   NO_RESULT},
        '{ROW_TYPED,   7'd0,   CMD_UNKNOWN_HI, 16'hFFFF,   ALL_ONES,   NO_RESULT},
        '{ROW_TYPED,   7'd0,   CMD_CLEAR,      16'd0,      64'd0,
          {1'b1, 6'd0, 16'd0, 64'd0}},
        '{ROW_TYPED,   7'd0,   CMD_FIND,       16'd2,      64'd0,      NO_RESULT},
        '{ROW_TYPED,   7'd0,   CMD_MODIFY,     16'd0,      ALL_ONES,   NO_RESULT},
        // Two slots: fill them, then an add must fail without using an id.
        '{ROW_CONFIG,  7'd2,   CMD_CLEAR,      16'd0,      64'd0,      NO_RESULT},
        '{ROW_PREDICT, 7'd0,   CMD_ADD,        16'd0,      64'd1,      NO_RESULT},
        '{ROW_PREDICT, 7'd0,   CMD_ADD,        16'd0,      64'd2,      NO_RESULT},
        '{ROW_TYPED,   7'd0,   CMD_ADD,        16'd0,      64'd3,      NO_RESULT},
        '{ROW_PREDICT, 7'd0,   CMD_REMOVE,     16'd5,      64'd0,      NO_RESULT},
        '{ROW_PREDICT, 7'd0,   CMD_ADD,        16'd0,      64'd4,      NO_RESULT},
        // No active slots: even clear fails.
        '{ROW_CONFIG,  7'd0,   CMD_CLEAR,      16'd0,      64'd0,      NO_RESULT},
        '{ROW_TYPED,   7'd0,   CMD_CLEAR,      16'd0,      64'd0,      NO_RESULT},
        '{ROW_TYPED,   7'd0,   CMD_ADD,        16'd0,      ALL_ONES,   NO_RESULT},
        // A size above the table counts as the whole table.
        '{ROW_CONFIG,  7'd127, CMD_CLEAR,      16'd0,      64'd0,      NO_RESULT},
        '{ROW_PREDICT, 7'd0,   CMD_FIND,       16'd4,      64'd0,      NO_RESULT},
        // One slot: clear leaves slot 1 alone, and it is out of reach.
        '{ROW_CONFIG,  7'd1,   CMD_CLEAR,      16'd0,      64'd0,      NO_RESULT},
        '{ROW_PREDICT, 7'd0,   CMD_CLEAR,      16'd0,      64'd0,      NO_RESULT},
        '{ROW_TYPED,   7'd0,   CMD_FIND,       16'd6,      64'd0,      NO_RESULT},
        '{ROW_CONFIG,  7'd64,  CMD_CLEAR,      16'd0,      64'd0,      NO_RESULT},
        '{ROW_PREDICT, 7'd0,   CMD_FIND,       16'd6,      64'd0,      NO_RESULT},
        '{ROW_PREDICT, 7'd0,   CMD_ADD,        16'd0,      64'hFEDC_BA98_7654_3210, NO_RESULT}
    };

    // Random phases: size, sender idle percentage, receiver stall
    // percentage, share of adds, and number of commands.
    phase_t phases [6] = '{
        '{7'd64,  0,  0,  45, 120},
        '{7'd5,   50, 0,  40, 120},
        '{7'd127, 0,  50, 60, 120},
        '{7'd1,   35, 35, 40, 90},
        '{7'd0,   50, 50, 40, 20},
        '{7'd33,  35, 35, 40, 120}
    };

    initial begin
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        int               pick;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_CLEAR;
        for (int i = 0; i < SLOTS; i++) copy_valid[i] = 1'b0;
        copy_next_id = '0;
        copy_active  = ACTIVE_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                write_active(directed_rows[i].active);
            end else begin
                send_command(directed_rows[i].op, directed_rows[i].key, directed_rows[i].pay,
                             directed_rows[i].kind == ROW_TYPED, directed_rows[i].want);
            end
        end

        foreach (phases[p]) begin
            write_active(phases[p].active);
            send_idle_pct  = phases[p].send_idle;
            recv_stall_pct = phases[p].recv_stall;
            repeat (phases[p].items) begin
                pick = $urandom_range(99);
                if (pick < phases[p].add_pct) begin
                    op = CMD_ADD;
                end else if (pick < phases[p].add_pct + 3) begin
                    op = CMD_CLEAR;
                end else if (pick < phases[p].add_pct + 7) begin
                    op = CMD_W'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
                end else begin
                    case (pick % 3)
                        0:       op = CMD_REMOVE;
                        1:       op = CMD_MODIFY;
                        default: op = CMD_FIND;
                    endcase
                end
                key = pick_key();
                case ($urandom_range(9))
                    0:       pay = '0;
                    1:       pay = ALL_ONES;
                    default: pay = {$urandom(), $urandom()};
                endcase
                send_command(op, key, pay, 1'b0, NO_RESULT);
            end
        end

        // Drain, then leave room for any stray result to show up.
        wait_idle();
        repeat (80) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
